@@ rtl/sorted_signature_table_lookup_top_defines.svh @@
// Assertion macros for the signature table lookup block.
// Used by sorted_signature_table_lookup_top; expects clk and rst in scope.
`ifndef SORTED_SIGNATURE_TABLE_LOOKUP_TOP_DEFINES_SVH
`define SORTED_SIGNATURE_TABLE_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication
`define SSTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sstl_pkg.sv @@
// Shared types and constants of the signature table lookup block.
// No dependencies; used by sstl_ctrl, sstl_dp and the top level.
`default_nettype none

package sstl_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;

  localparam int COUNT_W = 13;
  localparam int INDEX_W = 12;
  localparam int CRC_W   = 32;
  localparam int ID_W    = 16;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // s_tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]         pad;
    logic [ID_W-1:0]    threat_id_in;
    logic [CRC_W-1:0]   body_crc;
    logic [CRC_W-1:0]   file_length;
    logic [CRC_W-1:0]   win_header_crc;
    logic [CRC_W-1:0]   dos_header_crc;
    logic [INDEX_W-1:0] entry_index;
  } in_data_t;

  // m_tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]         pad;
    logic [INDEX_W-1:0] match_position;
    logic [ID_W-1:0]    threat_id;
  } out_data_t;

  typedef struct packed {
    logic [CRC_W-1:0] dos_crc;
    logic [CRC_W-1:0] win_crc;
    logic [CRC_W-1:0] size;
    logic [CRC_W-1:0] body_crc;
    logic [ID_W-1:0]  id;
  } rec_t;

  typedef enum logic [1:0] {
    RD_MID  = 2'd0,
    RD_PREV = 2'd1,
    RD_PTR  = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    wr_rec;
    logic    start;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    narrow;
    logic    take_mid;
    logic    dec;
    logic    inc;
    logic    emit;
    logic    emit_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic key_eq;
    logic ptr_zero;
    logic ptr_end;
    logic body_eq;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/sorted_signature_table_lookup_top.sv @@
// Signature table lookup: records sorted by (DOS CRC, window CRC, size) are
// written one per transfer; a query transfer runs a binary search, walks back
// to the first equal key and scans forward for a matching body CRC. A query
// holds s_tready low until its result is loaded into the output register;
// every table read first issues the address to the single read port of the
// record memory, then compares the registered data. Reads are up to
// ceil(log2(n + 1)) probes, n being entry_count saturated at the table
// depth, plus the walk-back and scan steps. The output register lets the next
// transfer in while a result waits on m_tready. The count register is written
// through cfg_valid/cfg_data and is always ready. Reading a table entry that
// was never written gives undefined fields. Depends on sstl_pkg, sstl_ctrl,
// sstl_dp and the defines header.
`default_nettype none

module sorted_signature_table_lookup_top #(
  parameter int TABLE_DEPTH = sstl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sstl_pkg::COUNT_W-1:0]    cfg_data,    // entry_count
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // entry_index, dos_header_crc, win_header_crc, file_length, body_crc,
  // threat_id_in, zero pad
  input  wire logic [sstl_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [0:0]                      s_tuser,     // cmd
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // threat_id, match_position, zero pad
  output logic [sstl_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [0:0]                           m_tuser      // status
);
  import sstl_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t stat;
  logic     status;

  assign cfg_ready = 1'b1;
  assign m_tuser   = status;

  sstl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (s_tuser[0]),
    .stat     (stat),
    .dp_cmd   (dp_cmd)
  );

  sstl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .dp_cmd    (dp_cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_status  (status)
  );

  `include "sorted_signature_table_lookup_top_defines.svh"

  `SSTL_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser[0] == CMD_QUERY), !s_tready, "query transfer did not block input")
  `SSTL_ASSERT_NEXT(a_write_one_cycle, s_tvalid && s_tready && (s_tuser[0] == CMD_WRITE), s_tready, "write transfer took more than one cycle")
  `SSTL_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "miss result carries nonzero data")
  `SSTL_ASSERT_NOW(a_emit_free, dp_cmd.emit, !m_tvalid || m_tready, "result overwrote a pending result")

endmodule

`default_nettype wire

@@ rtl/sstl_ctrl.sv @@
// Sequencer of the signature table lookup: search, walk back, forward scan.
// Depends on sstl_pkg; drives sstl_dp through dp_cmd_t.
`default_nettype none

module sstl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              cmd,
  input  wire sstl_pkg::dp_stat_t stat,
  output sstl_pkg::dp_cmd_t      dp_cmd
);
  import sstl_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_PROBE_RD  = 9'b000000010,
    ST_PROBE_CMP = 9'b000000100,
    ST_BACK_RD   = 9'b000001000,
    ST_BACK_CMP  = 9'b000010000,
    ST_SCAN_RD   = 9'b000100000,
    ST_SCAN_CMP  = 9'b001000000,
    ST_DONE_HIT  = 9'b010000000,
    ST_DONE_MISS = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    dp_cmd.rd_sel = RD_MID;
    case (state)
      ST_IDLE: begin
        dp_cmd.wr_rec = accept && (cmd == CMD_WRITE);
        dp_cmd.start  = accept && (cmd == CMD_QUERY);
        if (accept && (cmd == CMD_QUERY)) state_next = ST_PROBE_RD;
      end
      ST_PROBE_RD: begin
        if (stat.search_done) begin
          state_next = ST_DONE_MISS;
        end else begin
          dp_cmd.rd_en = 1'b1;
          state_next   = ST_PROBE_CMP;
        end
      end
      ST_PROBE_CMP: begin
        if (stat.key_eq) begin
          dp_cmd.take_mid = 1'b1;
          state_next      = ST_BACK_RD;
        end else begin
          dp_cmd.narrow = 1'b1;
          state_next    = ST_PROBE_RD;
        end
      end
      ST_BACK_RD: begin
        if (stat.ptr_zero) begin
          state_next = ST_SCAN_RD;
        end else begin
          dp_cmd.rd_en  = 1'b1;
          dp_cmd.rd_sel = RD_PREV;
          state_next    = ST_BACK_CMP;
        end
      end
      ST_BACK_CMP: begin
        if (stat.key_eq) begin
          dp_cmd.dec = 1'b1;
          state_next = ST_BACK_RD;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (stat.ptr_end) begin
          state_next = ST_DONE_MISS;
        end else begin
          dp_cmd.rd_en  = 1'b1;
          dp_cmd.rd_sel = RD_PTR;
          state_next    = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (!stat.key_eq) begin
          state_next = ST_DONE_MISS;
        end else if (stat.body_eq) begin
          state_next = ST_DONE_HIT;
        end else begin
          dp_cmd.inc = 1'b1;
          state_next = ST_SCAN_RD;
        end
      end
      ST_DONE_HIT: begin
        if (stat.out_free) begin
          dp_cmd.emit     = 1'b1;
          dp_cmd.emit_hit = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_DONE_MISS: begin
        if (stat.out_free) begin
          dp_cmd.emit = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sstl_dp.sv @@
// Datapath of the signature table lookup: record memory, search bounds,
// key compare, count register and output register. Depends on sstl_pkg.
`default_nettype none

module sstl_dp #(
  parameter int TABLE_DEPTH = sstl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [sstl_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic                            cfg_valid,
  input  wire logic [sstl_pkg::COUNT_W-1:0]    cfg_data,
  input  wire sstl_pkg::dp_cmd_t               dp_cmd,
  output sstl_pkg::dp_stat_t                   stat,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [sstl_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_status
);
  import sstl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  rec_t mem [TABLE_DEPTH];

  in_data_t            din;
  rec_t                rd_data;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                wr_in_range;
  logic [COUNT_W-1:0]  entry_count;
  logic [CW-1:0]       n_sat;
  logic [CW-1:0]       n_cur;
  logic [CW-1:0]       lo, hx, ptr;
  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid;
  logic [CW-1:0]       ptr_m1;
  logic [3*CRC_W-1:0]  q_key;
  logic [3*CRC_W-1:0]  e_key;
  logic [CRC_W-1:0]    q_body;
  logic                key_lt;
  out_data_t           out_data;

  assign din = in_data_t'(s_tdata);

  // table writes
  assign wr_in_range = (32'(din.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr     = AW'(din.entry_index);

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_rec && wr_in_range) begin
      mem[wr_addr] <= '{dos_crc:  din.dos_header_crc,
                        win_crc:  din.win_header_crc,
                        size:     din.file_length,
                        body_crc: din.body_crc,
                        id:       din.threat_id_in};
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid) begin
      entry_count <= cfg_data;
    end
  end

  assign n_sat = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                       : CW'(entry_count);

  // floor((lo + hi) / 2) with hi = hx - 1
  assign mid_sum = {1'b0, lo} + {1'b0, hx} - (CW + 1)'(1);
  assign mid     = mid_sum[CW:1];
  assign ptr_m1  = ptr - CW'(1);

  always_comb begin
    case (dp_cmd.rd_sel)
      RD_MID:  rd_addr = mid[AW-1:0];
      RD_PREV: rd_addr = ptr_m1[AW-1:0];
      RD_PTR:  rd_addr = ptr[AW-1:0];
      default: rd_addr = mid[AW-1:0];
    endcase
  end

  // query registers
  always_ff @(posedge clk) begin
    if (dp_cmd.start) begin
      q_key  <= {din.dos_header_crc, din.win_header_crc, din.file_length};
      q_body <= din.body_crc;
      n_cur  <= n_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.start) begin
      lo <= '0;
      hx <= n_sat;
    end else if (dp_cmd.narrow) begin
      if (key_lt) begin
        hx <= mid;
      end else begin
        lo <= mid + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.take_mid) begin
      ptr <= mid;
    end else if (dp_cmd.dec) begin
      ptr <= ptr_m1;
    end else if (dp_cmd.inc) begin
      ptr <= ptr + CW'(1);
    end
  end

  assign e_key  = {rd_data.dos_crc, rd_data.win_crc, rd_data.size};
  assign key_lt = (q_key < e_key);

  assign stat.search_done = (lo >= hx);
  assign stat.key_eq      = (q_key == e_key);
  assign stat.ptr_zero    = (ptr == '0);
  assign stat.ptr_end     = (ptr >= n_cur);
  assign stat.body_eq     = (rd_data.body_crc == q_body);
  assign stat.out_free    = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dp_cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      m_status <= dp_cmd.emit_hit;
      if (dp_cmd.emit_hit) begin
        out_data <= '{pad:            '0,
                      match_position: INDEX_W'(ptr),
                      threat_id:      rd_data.id};
      end else begin
        out_data <= '0;
      end
    end
  end

  assign m_tdata = OUT_DATA_W'(out_data);

endmodule

`default_nettype wire

@@ bench/tb_sorted_signature_table_lookup_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for sorted_signature_table_lookup_top: loads signature tables over
// the input stream, sets entry_count and checks every lookup result against a local
// model of the search. Depends on sstl_pkg and the top level RTL only.

module tb_sorted_signature_table_lookup_top;

  localparam int TABLE_DEPTH  = sstl_pkg::TABLE_DEPTH_DEF;
  localparam int CLK_HALF     = 5;
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_LIMIT_NS = 10_000_000;

  typedef struct {
    bit                         cmd;
    bit [sstl_pkg::INDEX_W-1:0] index;
    bit [95:0]                  key;   // {dos crc, window crc, file length}
    bit [31:0]                  body;
    bit [sstl_pkg::ID_W-1:0]    id;
  } table_op_t;

  typedef struct {
    bit                         status;
    bit [sstl_pkg::ID_W-1:0]    threat_id;
    bit [sstl_pkg::INDEX_W-1:0] match_position;
  } lookup_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [sstl_pkg::COUNT_W-1:0]      cfg_data = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [sstl_pkg::IN_DATA_W-1:0]    s_tdata = '0;  // entry_index .. threat_id_in, pad
  logic [0:0]                        s_tuser = '0;  // cmd
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [sstl_pkg::OUT_DATA_W-1:0]   m_tdata;       // threat_id, match_position, pad
  logic [0:0]                        m_tuser;       // status

  // predicted table state
  bit [31:0]               sig_dos  [TABLE_DEPTH];
  bit [31:0]               sig_win  [TABLE_DEPTH];
  bit [31:0]               sig_len  [TABLE_DEPTH];
  bit [31:0]               sig_body [TABLE_DEPTH];
  bit [sstl_pkg::ID_W-1:0] sig_id   [TABLE_DEPTH];
  bit [sstl_pkg::COUNT_W-1:0] active_count;

  // stimulus plan of the table being loaded
  bit [95:0]               plan_key  [TABLE_DEPTH];
  bit [31:0]               plan_body [TABLE_DEPTH];
  bit [sstl_pkg::ID_W-1:0] plan_id   [TABLE_DEPTH];

  table_op_t      table_ops_q[$];
  lookup_result_t expected_lookups[$];
  table_op_t      on_bus;
  sstl_pkg::in_data_t  bus_word;
  sstl_pkg::out_data_t res_word;
  lookup_result_t      want;

  int ops_queued, ops_accepted, writes_seen, results_checked, hits_seen;
  int table_loads, mismatches;
  int send_gap_pct, recv_stall_pct;

  sorted_signature_table_lookup_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // +1 when key lies above entry e, -1 below, 0 equal
  function automatic int key_order(int e, bit [95:0] key);
    bit [95:0] stored;
    stored = {sig_dos[e], sig_win[e], sig_len[e]};
    if (key > stored) return 1;
    if (key < stored) return -1;
    return 0;
  endfunction

  function automatic lookup_result_t lookup_signature(bit [95:0] key, bit [31:0] body);
    lookup_result_t r;
    int n, lo, hi, mid, c, i;
    bit hit;
    r = '{default: 0};
    n = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
    lo = 0;
    hi = n - 1;
    hit = 1'b0;
    mid = 0;
    while (!hit && lo <= hi) begin
      mid = (lo + hi) / 2;
      c = key_order(mid, key);
      if (c == 0) begin
        while (mid > 0 && key_order(mid - 1, key) == 0) mid--;
        hit = 1'b1;
      end else if (c < 0) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    if (hit) begin
      for (i = mid; i < n && !r.status && key_order(i, key) == 0; i++) begin
        if (sig_body[i] == body) begin
          r.status = 1'b1;
          r.threat_id = sig_id[i];
          r.match_position = i[sstl_pkg::INDEX_W-1:0];
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: lookup %0d: %s", $time, results_checked, msg);
    mismatches++;
  endtask

  // driver: presents queued operations, updates the prediction on each transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        ops_accepted++;
        if (on_bus.cmd == sstl_pkg::CMD_WRITE) begin
          sig_dos[on_bus.index]  = on_bus.key[95:64];
          sig_win[on_bus.index]  = on_bus.key[63:32];
          sig_len[on_bus.index]  = on_bus.key[31:0];
          sig_body[on_bus.index] = on_bus.body;
          sig_id[on_bus.index]   = on_bus.id;
          writes_seen++;
        end else begin
          expected_lookups.push_back(lookup_signature(on_bus.key, on_bus.body));
        end
      end
      if (!s_tvalid || s_tready) begin
        if (table_ops_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_bus = table_ops_q.pop_front();
          bus_word.pad            = '0;
          bus_word.threat_id_in   = on_bus.id;
          bus_word.body_crc       = on_bus.body;
          bus_word.file_length    = on_bus.key[31:0];
          bus_word.win_header_crc = on_bus.key[63:32];
          bus_word.dos_header_crc = on_bus.key[95:64];
          bus_word.entry_index    = on_bus.index;
          s_tvalid <= 1'b1;
          s_tdata  <= bus_word;
          s_tuser  <= on_bus.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        res_word = m_tdata;
        if (expected_lookups.size() == 0) begin
          report_mismatch("result with no lookup outstanding");
        end else begin
          want = expected_lookups.pop_front();
          if (m_tuser[0] !== want.status)
            report_mismatch($sformatf("status exp %0d got %0d", want.status, m_tuser[0]));
          if (res_word.threat_id !== want.threat_id)
            report_mismatch($sformatf("threat_id exp 0x%0h got 0x%0h",
                                      want.threat_id, res_word.threat_id));
          if (res_word.match_position !== want.match_position)
            report_mismatch($sformatf("match_position exp %0d got %0d",
                                      want.match_position, res_word.match_position));
          if (want.status) hits_seen++;
        end
        results_checked++;
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_write(bit [11:0] index, bit [95:0] key, bit [31:0] body,
                             bit [15:0] id);
    table_op_t op;
    op.cmd = sstl_pkg::CMD_WRITE;
    op.index = index;
    op.key = key;
    op.body = body;
    op.id = id;
    table_ops_q.push_back(op);
    ops_queued++;
  endtask

  task automatic queue_query(bit [95:0] key, bit [31:0] body);
    table_op_t op;
    op.cmd = sstl_pkg::CMD_QUERY;
    op.index = 12'($urandom);
    op.key = key;
    op.body = body;
    op.id = 16'($urandom);
    table_ops_q.push_back(op);
    ops_queued++;
  endtask

  // wait until the stream is drained and every lookup has answered
  task automatic wait_idle();
    while (ops_accepted != ops_queued || expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entry_count(bit [sstl_pkg::COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_count = value;
  endtask

  function automatic bit [31:0] rand_word();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // fill the plan with rows records (duplicate keys included), sort if asked, queue writes
  task automatic build_table(int rows, bit sorted);
    int i, j, src;
    bit [95:0] k;
    bit [31:0] b;
    bit [15:0] d;
    for (i = 0; i < rows; i++) begin
      if (i > 0 && $urandom_range(3) == 0) begin
        src = $urandom_range(i - 1);
        plan_key[i] = plan_key[src];
        plan_body[i] = $urandom_range(1) ? plan_body[src] : rand_word();
      end else begin
        plan_key[i] = {rand_word(), rand_word(), rand_word()};
        plan_body[i] = rand_word();
      end
      plan_id[i] = 16'($urandom);
    end
    if (sorted) begin
      for (i = 1; i < rows; i++) begin
        k = plan_key[i];
        b = plan_body[i];
        d = plan_id[i];
        j = i;
        while (j > 0 && plan_key[j-1] > k) begin
          plan_key[j] = plan_key[j-1];
          plan_body[j] = plan_body[j-1];
          plan_id[j] = plan_id[j-1];
          j--;
        end
        plan_key[j] = k;
        plan_body[j] = b;
        plan_id[j] = d;
      end
    end
    for (i = 0; i < rows; i++) queue_write(12'(i), plan_key[i], plan_body[i], plan_id[i]);
    table_loads++;
  endtask

  task automatic run_phase(int rows, int count, bit sorted, bit reload, int lookups);
    int q, j, pick;
    bit [95:0] key;
    bit [31:0] body;
    wait_idle();
    set_entry_count(13'(count));
    if (reload) build_table(rows, sorted);
    for (q = 0; q < lookups; q++) begin
      if (rows < TABLE_DEPTH && $urandom_range(7) == 0)
        queue_write(12'($urandom_range(TABLE_DEPTH - 1, rows)), {rand_word(), rand_word(),
                    rand_word()}, rand_word(), 16'($urandom));
      j = $urandom_range(rows - 1);
      pick = $urandom_range(99);
      key = plan_key[j];
      body = plan_body[j];
      if (pick >= 85) begin
        key = {rand_word(), rand_word(), rand_word()};
        body = rand_word();
      end else if (pick >= 65) begin
        key = $urandom_range(1) ? key + 96'd1 : key - 96'd1;
      end else if (pick >= 45) begin
        body = rand_word();
      end
      queue_query(key, body);
    end
  endtask

  initial begin
    int mode, k, rows, count;
    int lo, hi, mid;
    bit [95:0] k0, k1, k4, k5;
    send_gap_pct = 35;
    recv_stall_pct = 49;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, then a small table with extreme keys and a duplicate run
    k0 = '0;
    k1 = {32'h0, 32'hFFFF_FFFF, 32'd5};
    k4 = {32'd7, 64'h0};
    k5 = '1;
    set_entry_count(0);
    queue_query(k0, 32'h0);
    queue_query(k5, 32'hFFFF_FFFF);
    wait_idle();
    set_entry_count(6);
    queue_write(0, k0, 32'h0, 16'h0000);
    queue_write(1, k1, 32'h1234_5678, 16'h0001);
    queue_write(2, k1, 32'h9ABC_DEF0, 16'h0002);
    queue_write(3, k1, 32'h1234_5678, 16'h0003);
    queue_write(4, k4, 32'hFFFF_FFFF, 16'hFFFF);
    queue_write(5, k5, 32'hFFFF_FFFF, 16'h8001);
    queue_query(k0, 32'h0);
    queue_query(k1, 32'h1234_5678);
    queue_query(k1, 32'h9ABC_DEF0);
    queue_query(k5, 32'hFFFF_FFFF);
    queue_query(k4, 32'hFFFF_FFFF);
    queue_query(k1, 32'h0);
    queue_query(k1 - 96'd1, 32'h1234_5678);
    queue_query(k5 - 96'd1, 32'hFFFF_FFFF);
    wait_idle();
    set_entry_count(3);
    queue_query(k4, 32'hFFFF_FFFF);
    queue_query(k1, 32'h9ABC_DEF0);

    // random tables, sorted and unsorted, under three idle profiles
    for (mode = 0; mode < 3; mode++) begin
      send_gap_pct   = (mode == 0) ? 35 : (mode == 1) ? 49 : 0;
      recv_stall_pct = (mode == 0) ? 49 : (mode == 1) ? 35 : 0;
      for (k = 0; k < 8; k++) begin
        rows = $urandom_range(1, 48);
        count = ($urandom_range(3) == 0) ? $urandom_range(rows) : rows;
        run_phase(rows, count, $urandom_range(4) != 0, 1'b1, 26);
      end
    end

    // full-depth search: only the entries on the upper probe path are loaded
    wait_idle();
    set_entry_count(13'(TABLE_DEPTH));
    lo = 0;
    hi = TABLE_DEPTH - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      queue_write(12'(mid), k0, 32'h0, 16'h0000);
      lo = mid + 1;
    end
    queue_write(12'(TABLE_DEPTH - 1), k5, 32'h5A5A_0001, 16'hBEEF);
    queue_query(k5, 32'h5A5A_0001);
    queue_query(k5, 32'h0);
    queue_query(k4, 32'h0);
    // count saturated above the depth, then one below it
    wait_idle();
    set_entry_count(13'h1FFF);
    queue_query(k5, 32'h5A5A_0001);
    queue_query(k5, 32'hFFFF_FFFF);
    wait_idle();
    set_entry_count(13'(TABLE_DEPTH + 1));
    queue_query(k5, 32'h5A5A_0001);
    wait_idle();
    set_entry_count(13'(TABLE_DEPTH - 1));
    queue_query(k5, 32'h5A5A_0001);
    wait_idle();

    if (expected_lookups.size() != 0) report_mismatch("lookups left without a result");
    $display("Covered %0d table writes over %0d table loads and %0d lookups (%0d hits),",
             writes_seen, table_loads, results_checked, hits_seen);
    $display("entry counts from 0 up to the saturated maximum; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("tb_sorted_signature_table_lookup_top passed");
    end else begin
      $display("tb_sorted_signature_table_lookup_top failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_sorted_signature_table_lookup_top failed");
    $finish;
  end

endmodule
